// ===== hw/rtl/rrd_pkg.sv =====
package rrd_pkg;

   // Restoring square root: a 48-bit radicand gives a 24-bit root, two bits per step.
   localparam int ROOT_STEPS = 24;
   localparam int RAD_W = 2 * ROOT_STEPS;

   // Item mode codes.
   localparam logic MODE_REFLECT = 1'b0;
   localparam logic MODE_REFRACT = 1'b1;

   typedef struct packed {
      logic             mode;
      logic [2:0][19:0] n;
      logic [2:0][23:0] p;
   } rrd_side_type;

   function automatic logic signed [19:0] sat20(input logic signed [63:0] x);
      logic signed [19:0] r;
      if (x > 64'sd524287) begin
         r = 20'sd524287;
      end else if (x < -64'sd524288) begin
         r = -20'sd524288;
      end else begin
         r = x[19:0];
      end
      return r;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [63:0] x);
      logic signed [23:0] r;
      if (x > 64'sd8388607) begin
         r = 24'sd8388607;
      end else if (x < -64'sd8388608) begin
         r = -24'sd8388608;
      end else begin
         r = x[23:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/rrd_front.sv =====
module rrd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    in_valid,
   input  logic                    mode,
   input  logic [2:0][19:0]        v,
   input  logic [2:0][19:0]        n,
   input  logic [19:0]             eta,
   output logic                    out_valid,
   output rrd_pkg::rrd_side_type   out_side,
   output logic [rrd_pkg::RAD_W-1:0] out_diff
);

   localparam int NST = 10;

   logic             vld_ff  [1:NST];
   logic             mode_ff [1:NST];
   logic [2:0][19:0] n_ff    [1:NST];
   logic [2:0][19:0] v_ff    [1:4];
   logic [19:0]      eta_ff  [1:5];
   logic [2:0][19:0] refl_ff [4:6];
   logic [2:0][23:0] p_ff    [7:NST];

   logic signed [39:0] pr_ff [3];
   logic signed [39:0] pr_in [3];
   logic signed [41:0] dot_ff, dot_in;
   logic signed [61:0] rp_ff [3];
   logic signed [61:0] rp_in [3];
   logic signed [26:0] c_ff, c_in;
   logic signed [46:0] nc_ff [3];
   logic signed [46:0] nc_in [3];
   logic [2:0][19:0]   refl_in;
   logic signed [31:0] w_ff [3];
   logic signed [31:0] w_in [3];
   logic signed [52:0] we_ff [3];
   logic signed [52:0] we_in [3];
   logic [2:0][23:0]   p_in;
   logic [47:0]        sq_ff [3];
   logic [47:0]        sq_in [3];
   logic [47:0]        len_ff, len_in;
   logic [47:0]        diff_ff, diff_in;

   always_comb begin
      logic signed [42:0] m;
      logic signed [31:0] t;
      logic signed [23:0] pv;
      m = -(43'(dot_ff));
      if (m > 43'sd4294967296) begin
         m = 43'sd4294967296;
      end
      c_in = 27'((m + 43'sd32768) >>> 16);
      dot_in = 42'(pr_ff[0]) + 42'(pr_ff[1]) + 42'(pr_ff[2]);
      for (int i = 0; i < 3; i++) begin
         pr_in[i] = 40'($signed(v[i])) * 40'($signed(n[i]));
         rp_in[i] = 62'(dot_ff) * 62'($signed(n_ff[2][i]));
         t = 32'((64'(rp_ff[i]) + 64'sd1073741824) >>> 31);
         refl_in[i] = rrd_pkg::sat20(64'($signed(v_ff[3][i])) - 64'(t));
         nc_in[i] = 47'($signed(n_ff[3][i])) * 47'(c_ff);
         w_in[i] = 32'(((48'($signed(v_ff[4][i])) <<< 16) + 48'(nc_ff[i]) + 48'sd32768)
                       >>> 16);
         we_in[i] = 53'(w_ff[i]) * $signed({33'd0, eta_ff[5]});
         if (mode_ff[6] == rrd_pkg::MODE_REFRACT) begin
            p_in[i] = rrd_pkg::sat24((64'(we_ff[i]) + 64'sd32768) >>> 16);
         end else begin
            p_in[i] = 24'($signed(refl_ff[6][i]));
         end
         pv = $signed(p_ff[7][i]);
         sq_in[i] = 48'(48'(pv) * 48'(pv));
      end
      len_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
      if (len_ff >= 48'h1_0000_0000) begin
         diff_in = len_ff - 48'h1_0000_0000;
      end else begin
         diff_in = 48'h1_0000_0000 - len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NST; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[1] <= in_valid;
         for (int k = 2; k <= NST; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mode_ff[1] <= mode;
         n_ff[1]    <= n;
         v_ff[1]    <= v;
         eta_ff[1]  <= eta;
         for (int k = 2; k <= NST; k++) begin
            mode_ff[k] <= mode_ff[k-1];
            n_ff[k]    <= n_ff[k-1];
         end
         for (int k = 2; k <= 4; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
         for (int k = 2; k <= 5; k++) begin
            eta_ff[k] <= eta_ff[k-1];
         end
         refl_ff[4] <= refl_in;
         refl_ff[5] <= refl_ff[4];
         refl_ff[6] <= refl_ff[5];
         p_ff[7] <= p_in;
         for (int k = 8; k <= NST; k++) begin
            p_ff[k] <= p_ff[k-1];
         end
         for (int i = 0; i < 3; i++) begin
            pr_ff[i] <= pr_in[i];
            rp_ff[i] <= rp_in[i];
            nc_ff[i] <= nc_in[i];
            w_ff[i]  <= w_in[i];
            we_ff[i] <= we_in[i];
            sq_ff[i] <= sq_in[i];
         end
         dot_ff  <= dot_in;
         c_ff    <= c_in;
         len_ff  <= len_in;
         diff_ff <= diff_in;
      end
   end

   assign out_valid     = vld_ff[NST];
   assign out_side.mode = mode_ff[NST];
   assign out_side.n    = n_ff[NST];
   assign out_side.p    = p_ff[NST];
   assign out_diff      = diff_ff;

endmodule

// ===== hw/rtl/rrd_sqrt.sv =====
module rrd_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  rrd_pkg::rrd_side_type       in_side,
   input  logic [rrd_pkg::RAD_W-1:0]   in_rad,
   output logic                        out_valid,
   output rrd_pkg::rrd_side_type       out_side,
   output logic [rrd_pkg::ROOT_STEPS-1:0] out_root
);

   localparam int NS = rrd_pkg::ROOT_STEPS;
   localparam int W  = rrd_pkg::RAD_W;

   logic                  vld_ff  [1:NS];
   rrd_pkg::rrd_side_type side_ff [1:NS];
   logic [W-1:0]          x_ff    [1:NS];
   logic [W-1:0]          r_ff    [1:NS];

   logic                  vld_i  [0:NS-1];
   rrd_pkg::rrd_side_type side_i [0:NS-1];
   logic [W-1:0]          x_i    [0:NS-1];
   logic [W-1:0]          r_i    [0:NS-1];

   assign vld_i[0]  = in_valid;
   assign side_i[0] = in_side;
   assign x_i[0]    = in_rad;
   assign r_i[0]    = '0;

   for (genvar k = 0; k < NS; k++) begin : g_step
      localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
      logic [W-1:0] trial;
      logic [W-1:0] x_in, r_in;

      if (k > 0) begin : g_link
         assign vld_i[k]  = vld_ff[k];
         assign side_i[k] = side_ff[k];
         assign x_i[k]    = x_ff[k];
         assign r_i[k]    = r_ff[k];
      end

      // One bit of the root per stage: take the trial subtraction when it fits.
      always_comb begin
         trial = r_i[k] + BIT;
         if (x_i[k] >= trial) begin
            x_in = x_i[k] - trial;
            r_in = (r_i[k] >> 1) + BIT;
         end else begin
            x_in = x_i[k];
            r_in = r_i[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[k+1] <= vld_i[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k+1] <= side_i[k];
            x_ff[k+1]    <= x_in;
            r_ff[k+1]    <= r_in;
         end
      end
   end

   assign out_valid = vld_ff[NS];
   assign out_side  = side_ff[NS];
   assign out_root  = r_ff[NS][NS-1:0];

endmodule

// ===== hw/rtl/rrd_back.sv =====
module rrd_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic                           in_valid,
   input  rrd_pkg::rrd_side_type          in_side,
   input  logic [rrd_pkg::ROOT_STEPS-1:0] in_root,
   output logic                           out_valid,
   output logic signed [19:0]             out_x,
   output logic signed [19:0]             out_y,
   output logic signed [19:0]             out_z
);

   logic               vld1_ff, vld2_ff;
   logic               mode_ff;
   logic [2:0][23:0]   p_ff;
   logic signed [44:0] ps_ff [3];
   logic signed [44:0] ps_in [3];
   logic [2:0][19:0]   res_ff, res_in;

   always_comb begin
      logic signed [45:0] neg;
      logic signed [29:0] par;
      for (int i = 0; i < 3; i++) begin
         ps_in[i] = 45'($signed({1'b0, in_root})) * 45'($signed(in_side.n[i]));
         neg = -(46'(ps_ff[i]));
         par = 30'((neg + 46'sd32768) >>> 16);
         if (mode_ff == rrd_pkg::MODE_REFRACT) begin
            res_in[i] = rrd_pkg::sat20(64'($signed(p_ff[i])) + 64'(par));
         end else begin
            res_in[i] = p_ff[i][19:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mode_ff <= in_side.mode;
         p_ff    <= in_side.p;
         for (int i = 0; i < 3; i++) begin
            ps_ff[i] <= ps_in[i];
         end
         res_ff <= res_in;
      end
   end

   assign out_valid = vld2_ff;
   assign out_x     = res_ff[0];
   assign out_y     = res_ff[1];
   assign out_z     = res_ff[2];

endmodule

// ===== hw/rtl/reflect_refract_direction.sv =====
// Reflects an incident direction about a surface normal (mode 0) or refracts it
// by Snell's law with index ratio eta (mode 1): vectors in signed Q3.16, eta in
// unsigned Q4.16, results saturated. It takes one item every cycle while the
// result side accepts, through ten stages of dot product, scaling and squared
// length, 24 stages of the bit-per-stage square root, and two stages that apply
// the parallel part in refract mode and saturate. When the result side stalls,
// the whole pipeline holds, and req_ready falls with it.
module reflect_refract_direction (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic signed [19:0] req_incident_x,
   input  logic signed [19:0] req_incident_y,
   input  logic signed [19:0] req_incident_z,
   input  logic signed [19:0] req_normal_x,
   input  logic signed [19:0] req_normal_y,
   input  logic signed [19:0] req_normal_z,
   input  logic        [19:0] req_eta_ratio,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [19:0] rsp_out_x,
   output logic signed [19:0] rsp_out_y,
   output logic signed [19:0] rsp_out_z
);

   logic                             adv;
   logic                             front_valid, root_valid;
   rrd_pkg::rrd_side_type            front_side, root_side;
   logic [rrd_pkg::RAD_W-1:0]        front_diff;
   logic [rrd_pkg::ROOT_STEPS-1:0]   root;
   logic [2:0][19:0]                 v_vec, n_vec;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   assign v_vec = {req_incident_z, req_incident_y, req_incident_x};
   assign n_vec = {req_normal_z, req_normal_y, req_normal_x};

   rrd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .mode      (req_mode),
      .v         (v_vec),
      .n         (n_vec),
      .eta       (req_eta_ratio),
      .out_valid (front_valid),
      .out_side  (front_side),
      .out_diff  (front_diff)
   );

   rrd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_side   (front_side),
      .in_rad    (front_diff),
      .out_valid (root_valid),
      .out_side  (root_side),
      .out_root  (root)
   );

   rrd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (root_valid),
      .in_side   (root_side),
      .in_root   (root),
      .out_valid (rsp_valid),
      .out_x     (rsp_out_x),
      .out_y     (rsp_out_y),
      .out_z     (rsp_out_z)
   );

endmodule
